@@ rtl/tlwm_pkg.sv @@
// Package for the text line and word matcher.
// Holds sizes, control-register indexes, character codes and payload types.
// No dependencies.
package tlwm_pkg;

   localparam int PAT_MAX     = 29;
   localparam int PAT_REGS    = 4;
   localparam int PAT_LEN_W   = 5;
   localparam int ITEM_LEN_W  = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   localparam int DEF_MAX_LINE = 256;
   localparam int DEF_MAX_WORD = 30;

   // control register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LEN     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LOW     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_SECOND  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_THIRD   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_HIGH    = 3'd5;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic                  matched;
      logic [ITEM_LEN_W-1:0] item_length;
   } rsp_type;

   // pattern as seen by the matching core
   typedef struct packed {
      logic                         mode;
      logic [PAT_LEN_W-1:0]         len;      // clamped to PAT_MAX
      logic [PAT_MAX-1:0][7:0]      bytes;    // pattern byte i at index i
      logic [PAT_MAX-1:0][7:0]      aligned;  // aligned[k] = bytes[len-1-k]
      logic [PAT_MAX-1:0]           mask;     // mask[k] = k < len
   } pat_cfg_type;

endpackage

@@ rtl/tlwm_pattern.sv @@
// Control registers of the matcher: mode, pattern length and pattern bytes.
// Also keeps a registered copy of the pattern reversed against the window.
// Depends on tlwm_pkg.
module tlwm_pattern
   import tlwm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output pat_cfg_type            cfg
);

   logic                          mode_ff, mode_in;
   logic [PAT_LEN_W-1:0]          len_ff, len_in;
   logic [PAT_REGS-1:0][CSR_DATA_W-1:0] pat_ff, pat_in;
   logic [PAT_MAX-1:0][7:0]       aligned_ff, aligned_in;
   logic [PAT_MAX-1:0]            mask_ff, mask_in;
   logic [PAT_MAX-1:0][7:0]       pat_bytes, pat_bytes_in;

   always_comb begin
      mode_in = mode_ff;
      len_in  = len_ff;
      pat_in  = pat_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MODE:       mode_in   = csr_wdata[0];
            CSR_PAT_LEN: begin
               // low 5 bits; lengths over the window size act as window size
               if (csr_wdata[PAT_LEN_W-1:0] > PAT_LEN_W'(PAT_MAX))
                  len_in = PAT_LEN_W'(PAT_MAX);
               else
                  len_in = csr_wdata[PAT_LEN_W-1:0];
            end
            CSR_PAT_LOW:    pat_in[0] = csr_wdata;
            CSR_PAT_SECOND: pat_in[1] = csr_wdata;
            CSR_PAT_THIRD:  pat_in[2] = csr_wdata;
            CSR_PAT_HIGH:   pat_in[3] = csr_wdata;
            default:        ;
         endcase
      end
   end

   for (genvar i = 0; i < PAT_MAX; i++) begin : g_bytes
      assign pat_bytes[i]    = pat_ff[i / 8][(i % 8) * 8 +: 8];
      assign pat_bytes_in[i] = pat_in[i / 8][(i % 8) * 8 +: 8];
   end

   // built from the next register values so it changes in step with them
   for (genvar k = 0; k < PAT_MAX; k++) begin : g_align
      logic [PAT_LEN_W-1:0] src;
      assign src           = len_in - PAT_LEN_W'(k) - PAT_LEN_W'(1);
      assign mask_in[k]    = PAT_LEN_W'(k) < len_in;
      assign aligned_in[k] = mask_in[k] ? pat_bytes_in[src] : 8'h00;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         len_ff  <= '0;
         pat_ff  <= '0;
         mask_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
         pat_ff  <= pat_in;
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      aligned_ff <= aligned_in;
   end

   assign cfg.mode    = mode_ff;
   assign cfg.len     = len_ff;
   assign cfg.bytes   = pat_bytes;
   assign cfg.aligned = aligned_ff;
   assign cfg.mask    = mask_ff;

endmodule

@@ rtl/tlwm_core.sv @@
// Matching core: byte window, substring compare, greedy one-insertion word
// matcher and item length count. Processes one request per enabled cycle.
// Depends on tlwm_pkg.
module tlwm_core
   import tlwm_pkg::*;
#(
   parameter int MAX_LINE = DEF_MAX_LINE,
   parameter int MAX_WORD = DEF_MAX_WORD
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     item,
   input  pat_cfg_type cfg,
   output logic        res_valid,
   output rsp_type     res
);

   localparam logic [ITEM_LEN_W-1:0] LINE_LIMIT = ITEM_LEN_W'(MAX_LINE - 1);
   localparam logic [ITEM_LEN_W-1:0] WORD_LIMIT = ITEM_LEN_W'(MAX_WORD - 1);

   logic [PAT_MAX-1:0][7:0]  window_ff, window_in;
   logic [ITEM_LEN_W-1:0]    count_ff, count_in;
   logic                     found_ff, found_in;
   logic [PAT_LEN_W-1:0]     pos_ff, pos_in;
   logic                     ins_ff, ins_in;
   logic                     failed_ff, failed_in;

   logic [PAT_MAX-1:0][7:0]  window_new;
   logic [PAT_MAX-1:0]       lane_ok;
   logic [ITEM_LEN_W-1:0]    count_inc;
   logic [ITEM_LEN_W-1:0]    limit;
   logic [PAT_LEN_W-1:0]     pos_sel;
   logic                     sep, hit, close, keep, word_step;

   assign window_new = {window_ff[PAT_MAX-2:0], item.text_byte};
   assign count_inc  = count_ff + ITEM_LEN_W'(1);
   assign limit      = cfg.mode ? WORD_LIMIT : LINE_LIMIT;

   for (genvar k = 0; k < PAT_MAX; k++) begin : g_cmp
      assign lane_ok[k] = !cfg.mask[k] || (window_new[k] == cfg.aligned[k]);
   end

   // pattern ends at the new byte; the count check keeps stale window bytes out
   assign hit = (cfg.len != '0) && (count_inc >= ITEM_LEN_W'(cfg.len)) && (&lane_ok);

   assign pos_sel   = (pos_ff < PAT_LEN_W'(PAT_MAX)) ? pos_ff : '0;
   assign word_step = (pos_ff < cfg.len) && (item.text_byte == cfg.bytes[pos_sel]);

   assign sep = (item.text_byte == CHAR_NEWLINE) ||
                (cfg.mode && ((item.text_byte == CHAR_SPACE) ||
                              (item.text_byte == CHAR_TAB)));

   always_comb begin
      close = 1'b0;
      keep  = 1'b0;
      if (step) begin
         if (item.end_of_input)
            close = (count_ff != '0);
         else if (sep || (count_ff >= limit))
            close = 1'b1;
         else
            keep = 1'b1;
      end
   end

   always_comb begin
      window_in = window_ff;
      count_in  = count_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      ins_in    = ins_ff;
      failed_in = failed_ff;
      if (close) begin
         count_in  = '0;
         found_in  = 1'b0;
         pos_in    = '0;
         ins_in    = 1'b0;
         failed_in = 1'b0;
      end else if (keep) begin
         window_in = window_new;
         count_in  = count_inc;
         found_in  = found_ff || hit;
         if (!failed_ff) begin
            if (word_step)
               pos_in = pos_ff + PAT_LEN_W'(1);
            else if (!ins_ff)
               ins_in = 1'b1;
            else
               failed_in = 1'b1;
         end
      end
   end

   assign res_valid       = close;
   assign res.matched     = cfg.mode ? (!failed_ff && (pos_ff == cfg.len)) : found_ff;
   assign res.item_length = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         found_ff  <= 1'b0;
         pos_ff    <= '0;
         ins_ff    <= 1'b0;
         failed_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         found_ff  <= found_in;
         pos_ff    <= pos_in;
         ins_ff    <= ins_in;
         failed_ff <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

endmodule

@@ rtl/text_line_and_word_matcher.sv @@
// Text line and word matcher, top level.
// Channels: req_ carries one text byte or an end-of-input mark per request;
// rsp_ carries one result (match flag and kept length) per closed line or word;
// csr_ writes the mode, the pattern length and the four pattern byte words.
// Mode 0 reports each newline-ended line and whether it contains the pattern;
// mode 1 reports each word (space, tab, newline) and whether it equals the
// pattern with at most one inserted byte. Over-long items close early.
// A request is taken into the input register and its result, if any, is
// written to the result register when the core steps. Throughput: one request
// per cycle while the receiver does not stall, set by the input register, the
// combinational compare of the 29-byte window and the result register.
// A request that closes nothing gives no result.
// Reset (synchronous) clears the item state, the registers and both valids.
// When the receiver stalls, the result register holds and at most one more
// request enters the input register; req_ready then drops until rsp_ready rises.
// csr_ready is high outside reset; write registers only while the block is idle.
// Depends on tlwm_pkg, tlwm_pattern and tlwm_core.
module text_line_and_word_matcher
   import tlwm_pkg::*;
#(
   parameter int MAX_LINE = DEF_MAX_LINE,
   parameter int MAX_WORD = DEF_MAX_WORD
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic        in_vld_ff, in_vld_in;
   req_type     in_data_ff;
   logic        out_vld_ff, out_vld_in;
   rsp_type     out_data_ff;
   logic        out_free, step, core_valid;
   rsp_type     core_res;
   pat_cfg_type cfg;

   assign out_free  = !out_vld_ff || rsp_ready;
   assign step      = in_vld_ff && out_free;
   assign req_ready = !reset && (!in_vld_ff || out_free);
   assign csr_ready = !reset;

   tlwm_pattern u_pattern (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tlwm_core #(
      .MAX_LINE (MAX_LINE),
      .MAX_WORD (MAX_WORD)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_data_ff),
      .cfg       (cfg),
      .res_valid (core_valid),
      .res       (core_res)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready)
         in_vld_in = 1'b1;
      else if (step)
         in_vld_in = 1'b0;
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (step && core_valid)
         out_vld_in = 1'b1;
      else if (rsp_ready)
         out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready)
         in_data_ff <= req_data;
      if (step && core_valid)
         out_data_ff <= core_res;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ rtl/tlwm_checker.sv @@
// Port-level checks for the text line and word matcher, bound to the top level.
// Depends on tlwm_pkg and text_line_and_word_matcher.
module tlwm_checker
   import tlwm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // a fresh result must follow an accepted request
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a request");

   // back-pressure only when a result is waiting
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without a stalled result");

endmodule

bind text_line_and_word_matcher tlwm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/text_line_and_word_matcher_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for text_line_and_word_matcher: a directed table, then
// random text against random patterns, checked by a local line/word predictor and by typed table rows.
// Depends on tlwm_pkg and the matcher RTL.
module text_line_and_word_matcher_tb;
   import tlwm_pkg::*;

   localparam int          HALF_PERIOD    = 4;
   localparam int          RESET_CYCLES   = 10;
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          ITEM_TARGET    = 1400;
   localparam int          LONG_LINE      = 258;
   localparam int          REPORT_LIMIT   = 10;
   localparam logic        MODE_LINE      = 1'b0;
   localparam logic        MODE_WORD      = 1'b1;
   localparam logic [2:0]  CSR_SPARE_A    = 3'd6;
   localparam logic [2:0]  CSR_SPARE_B    = 3'd7;
   localparam logic [7:0]  LETTER_A       = 8'h61;

   typedef struct packed {
      logic                   is_cfg;
      logic [CSR_INDEX_W-1:0] cfg_index;
      logic [CSR_DATA_W-1:0]  cfg_value;
      req_type                req;
      logic                   typed;      // expected result written in the row
      logic                   has_rsp;
      rsp_type                rsp;
   } script_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   text_line_and_word_matcher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor copy of the registers and the item state
   logic        cfg_mode = MODE_LINE;
   logic [4:0]  cfg_len  = '0;
   logic [63:0] cfg_pat [PAT_REGS];
   logic [7:0]  win_bytes [PAT_MAX];
   int unsigned item_bytes;
   bit          line_hit;
   int unsigned word_pos;
   bit          word_skip_used;
   bit          word_dead;

   rsp_type        pending_results [$];
   script_row_type script_q [$];
   int unsigned    items_sent = 0;
   int unsigned    mismatches = 0;
   int unsigned    gap_max    = 9;
   int unsigned    stall_max  = 9;
   int unsigned    rsp_wait   = 0;
   int unsigned    idle_cycles = 0;

   function automatic int unsigned eff_len();
      return (cfg_len > PAT_MAX) ? PAT_MAX : int'(cfg_len);
   endfunction

   function automatic logic [7:0] pat_at(int unsigned i);
      return cfg_pat[(i >> 3) & 3][(i & 7) * 8 +: 8];
   endfunction

   function automatic void clear_item();
      foreach (win_bytes[k]) win_bytes[k] = '0;
      item_bytes     = 0;
      line_hit       = 1'b0;
      word_pos       = 0;
      word_skip_used = 1'b0;
      word_dead      = 1'b0;
   endfunction

   function automatic void close_item(output rsp_type res);
      if (cfg_mode == MODE_WORD)
         res.matched = !word_dead && (word_pos == eff_len());
      else
         res.matched = line_hit;
      res.item_length = item_bytes[7:0];
      clear_item();
   endfunction

   // one text request through the matcher; returns 1 when a line or word closes
   function automatic bit match_step(req_type r, output rsp_type res);
      int unsigned plen, limit, k;
      bit          is_sep, same;
      plen  = eff_len();
      limit = (cfg_mode == MODE_WORD) ? DEF_MAX_WORD - 1 : DEF_MAX_LINE - 1;
      res   = '0;
      if (r.end_of_input) begin
         if (item_bytes == 0) return 1'b0;
         close_item(res);
         return 1'b1;
      end
      is_sep = (r.text_byte == CHAR_NEWLINE) ||
               (cfg_mode == MODE_WORD &&
                (r.text_byte == CHAR_SPACE || r.text_byte == CHAR_TAB));
      if (is_sep || item_bytes >= limit) begin
         close_item(res);
         return 1'b1;
      end
      for (k = PAT_MAX - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = r.text_byte;
      item_bytes++;
      if (plen > 0 && item_bytes >= plen) begin
         same = 1'b1;
         for (k = 0; k < plen; k++)
            if (win_bytes[k] != pat_at(plen - 1 - k)) same = 1'b0;
         if (same) line_hit = 1'b1;
      end
      // greedy word match: first byte off the pattern is the one insertion
      if (!word_dead) begin
         if (word_pos < plen && r.text_byte == pat_at(word_pos))
            word_pos++;
         else if (!word_skip_used)
            word_skip_used = 1'b1;
         else
            word_dead = 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic script_row_type req_row(logic [7:0] b, logic eoi = 1'b0,
         logic typed = 1'b0, logic has = 1'b0, logic m = 1'b0, logic [7:0] len = 8'd0);
      script_row_type row;
      row                  = '0;
      row.req.text_byte    = b;
      row.req.end_of_input = eoi;
      row.typed            = typed;
      row.has_rsp          = has;
      row.rsp.matched      = m;
      row.rsp.item_length  = len;
      return row;
   endfunction

   function automatic script_row_type cfg_row(logic [CSR_INDEX_W-1:0] idx,
         logic [CSR_DATA_W-1:0] value);
      script_row_type row;
      row           = '0;
      row.is_cfg    = 1'b1;
      row.cfg_index = idx;
      row.cfg_value = value;
      return row;
   endfunction

   function automatic logic [7:0] pick_letter();
      return 8'(LETTER_A + $urandom_range(0, 3));
   endfunction

   function automatic logic [7:0] noise_byte();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return pick_letter();
      if (pick < 9) return 8'($urandom);
      return ($urandom_range(0, 1) != 0) ? CHAR_SPACE : CHAR_TAB;
   endfunction

   task automatic send_request(req_type r, logic typed = 1'b0, logic has = 1'b0,
         rsp_type given = '0);
      int unsigned gap;
      rsp_type     res;
      bit          got;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      if (!(r.end_of_input && item_bytes == 0)) items_sent++;
      got = match_step(r, res);
      if (typed) begin
         if (has) pending_results.push_back(given);
      end else if (got) begin
         pending_results.push_back(res);
      end
   endtask

   task automatic send_text(logic [7:0] b);
      send_request('{text_byte: b, end_of_input: 1'b0});
   endtask

   task automatic close_text();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         send_request('{text_byte: 8'($urandom), end_of_input: 1'b1});
      else if (cfg_mode != MODE_WORD || pick < 4)
         send_text(CHAR_NEWLINE);
      else if (pick < 7)
         send_text(CHAR_SPACE);
      else
         send_text(CHAR_TAB);
   endtask

   // lines or words: mostly the pattern with at most one edit, else noise, letters or bare closes
   task automatic emit_item();
      int unsigned plen, kind, edit, spot, n, i;
      plen = eff_len();
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         edit = $urandom_range(0, 3);   // exact, insertion, substitution, truncation
         spot = $urandom_range(0, plen);
         if (cfg_mode == MODE_LINE) repeat ($urandom_range(0, 4)) send_text(noise_byte());
         for (i = 0; i <= plen; i++) begin
            if (i == spot && edit == 1) send_text(noise_byte());
            if (i < plen) begin
               if (i == spot && edit == 2)
                  send_text(noise_byte());
               else if (!(edit == 3 && i >= spot))
                  send_text(pat_at(i));
            end
         end
         if (cfg_mode == MODE_LINE || $urandom_range(0, 3) == 0)
            repeat ($urandom_range(0, 3)) send_text(noise_byte());
         close_text();
      end else if (kind <= 7) begin
         repeat ($urandom_range(0, 8)) send_text(noise_byte());
         close_text();
      end else if (kind == 8) begin
         n = (cfg_mode == MODE_WORD) ? $urandom_range(27, 33) : $urandom_range(30, 60);
         repeat (n) send_text(pick_letter());
         close_text();
      end else begin
         repeat ($urandom_range(1, 3)) close_text();
      end
   endtask

   // sender holds off until every result is back and the pipe has emptied
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MODE:       cfg_mode   = value[0];
         CSR_PAT_LEN:    cfg_len    = value[PAT_LEN_W-1:0];
         CSR_PAT_LOW:    cfg_pat[0] = value;
         CSR_PAT_SECOND: cfg_pat[1] = value;
         CSR_PAT_THIRD:  cfg_pat[2] = value;
         CSR_PAT_HIGH:   cfg_pat[3] = value;
         default: ;
      endcase
   endtask

   task automatic compare_result(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         if (mismatches < REPORT_LIMIT)
            $display("unexpected result: matched=%0d length=%0d",
                     got.matched, got.item_length);
         mismatches++;
      end else begin
         want = pending_results.pop_front();
         if (got.matched !== want.matched || got.item_length !== want.item_length) begin
            if (mismatches < REPORT_LIMIT)
               $display("result mismatch: expected matched=%0d length=%0d, got matched=%0d length=%0d",
                        want.matched, want.item_length, got.matched, got.item_length);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            compare_result(rsp_data);
            rsp_wait = $urandom_range(0, stall_max);
         end else if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
         end
         rsp_ready <= (rsp_wait == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned  phase, phase_end, bi;
      logic [255:0] pat_bits;
      logic         next_mode;
      logic [4:0]   next_len;

      foreach (cfg_pat[k]) cfg_pat[k] = '0;
      clear_item();

      // reset state: empty pattern, line mode
      script_q.push_back(req_row("x"));
      script_q.push_back(req_row(CHAR_NEWLINE, 1'b0, 1'b1, 1'b1, 1'b0, 8'd1));
      script_q.push_back(req_row(CHAR_NEWLINE, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0));
      script_q.push_back(req_row(8'hFF, 1'b1, 1'b1));
      script_q.push_back(req_row(8'h00));
      script_q.push_back(req_row(8'hFF));
      script_q.push_back(req_row(8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'd2));
      // substring "ab" in lines
      script_q.push_back(cfg_row(CSR_PAT_LEN, 64'd2));
      script_q.push_back(cfg_row(CSR_PAT_LOW, 64'h6261));
      script_q.push_back(req_row("a"));
      script_q.push_back(req_row("b"));
      script_q.push_back(req_row(CHAR_NEWLINE));
      script_q.push_back(req_row("a"));
      script_q.push_back(req_row(CHAR_NEWLINE));
      // words: one insertion, short word, trailing insertion closed by end of input
      script_q.push_back(cfg_row(CSR_MODE, 64'(MODE_WORD)));
      script_q.push_back(req_row("a"));
      script_q.push_back(req_row("x"));
      script_q.push_back(req_row("b"));
      script_q.push_back(req_row(CHAR_SPACE));
      script_q.push_back(req_row("a"));
      script_q.push_back(req_row(CHAR_TAB));
      script_q.push_back(req_row("a"));
      script_q.push_back(req_row("b"));
      script_q.push_back(req_row("c"));
      script_q.push_back(req_row(8'hFF, 1'b1));
      // unused register indexes, then the empty pattern in word mode
      script_q.push_back(cfg_row(CSR_SPARE_A, '1));
      script_q.push_back(cfg_row(CSR_SPARE_B, '1));
      script_q.push_back(cfg_row(CSR_PAT_LEN, 64'd0));
      script_q.push_back(req_row("q"));
      script_q.push_back(req_row(CHAR_SPACE));
      script_q.push_back(req_row(CHAR_SPACE, 1'b0, 1'b1, 1'b1, 1'b1, 8'd0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (script_q[i]) begin
         if (script_q[i].is_cfg) begin
            wait_idle();
            write_reg(script_q[i].cfg_index, script_q[i].cfg_value);
         end else begin
            send_request(script_q[i].req, script_q[i].typed, script_q[i].has_rsp,
                         script_q[i].rsp);
         end
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         for (bi = 0; bi < 32; bi++)
            pat_bits[bi*8 +: 8] = ($urandom_range(0, 9) < 8) ? pick_letter() : 8'($urandom);
         next_mode = 1'($urandom_range(0, 1));
         next_len  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(1, 6));
         case (phase)
            0: begin next_mode = MODE_LINE; next_len = 5'd29; end
            1: begin next_mode = MODE_WORD; next_len = 5'd31; end
            2: begin next_mode = MODE_WORD; next_len = 5'd0; end
            3: begin next_mode = MODE_LINE; next_len = 5'd0; pat_bits = '1; end
            4: begin next_mode = MODE_WORD; next_len = 5'd1; pat_bits = '0; end
            default: ;
         endcase
         wait_idle();
         write_reg(CSR_MODE, 64'(next_mode));
         write_reg(CSR_PAT_LEN, 64'(next_len));
         write_reg(CSR_PAT_LOW, pat_bits[63:0]);
         write_reg(CSR_PAT_SECOND, pat_bits[127:64]);
         write_reg(CSR_PAT_THIRD, pat_bits[191:128]);
         write_reg(CSR_PAT_HIGH, pat_bits[255:192]);
         gap_max   = (phase % 3 == 1) ? 0 : 9;
         stall_max = (phase % 4 == 2) ? 0 : 9;
         // over-long line: 255 kept, the next byte dropped and the line closed
         if (phase == 0) repeat (LONG_LINE) send_text(pick_letter());
         phase_end = items_sent + $urandom_range(80, 160);
         while (items_sent < phase_end) emit_item();
         phase++;
      end

      wait_idle();
      if (mismatches == 0 && pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tlwm_pkg.sv
rtl/tlwm_pattern.sv
rtl/tlwm_core.sv
rtl/text_line_and_word_matcher.sv
rtl/tlwm_checker.sv
tb/text_line_and_word_matcher_tb.sv
